// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/lcle_pkg.sv =====
// shared types, codes and defaults for the line envelope core
package lcle_pkg;

   localparam int NODE_COUNT_DEFAULT = 1024;
   localparam int COORD_BITS_DEFAULT = 32;
   localparam int LINE_BITS          = 32;
   localparam int VALUE_BITS         = 64;
   localparam int STATUS_BITS        = 2;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 32;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OUTSIDE = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOMAIN_LOW   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOMAIN_HIGH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEEP_MAXIMUM = 2'd2;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] domain_low;
      logic [CSR_DATA_BITS-1:0] domain_high;
      logic                     keep_maximum;
   } cfg_type;

   typedef struct packed {
      logic                        operation;
      logic signed [LINE_BITS-1:0] line_slope;
      logic signed [LINE_BITS-1:0] line_intercept;
      logic signed [LINE_BITS-1:0] query_x;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] best_value;
      logic signed [LINE_BITS-1:0]  best_slope;
      logic signed [LINE_BITS-1:0]  best_intercept;
      logic [STATUS_BITS-1:0]       status;
   } rsp_type;

endpackage

// ===== rtl/lcle_node_ram.sv =====
// node pool memory: one write port, one registered read port
module lcle_node_ram
   import lcle_pkg::*;
#(
   parameter int DEPTH     = NODE_COUNT_DEFAULT,
   parameter int DATA_BITS = 2 * LINE_BITS + 20
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_BITS-1:0]          wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_BITS-1:0]          rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lcle_walker.sv =====
// tree walker: sequences node reads, line compares and write-backs
module lcle_walker
   import lcle_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   input  cfg_type cfg,
   input  logic    take,
   output logic    busy,
   output logic    done,
   output rsp_type result
);

   localparam int NW = $clog2(NODE_COUNT);
   localparam int UW = $clog2(NODE_COUNT + 1);
   localparam int DW = LINE_BITS + 1;
   localparam int PW = DW + COORD_BITS;
   localparam int EW = PW + 1;
   localparam int NB = 2 * LINE_BITS + 2 * NW;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_LOAD, S_MUL, S_CMP, S_ALLOC, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic                         op_ff, op_in;
   logic signed [LINE_BITS-1:0]  slope_ff, slope_in;
   logic signed [LINE_BITS-1:0]  icpt_ff, icpt_in;
   logic signed [COORD_BITS-1:0] x_ff, x_in;
   logic signed [COORD_BITS-1:0] lo_ff, lo_in;
   logic signed [COORD_BITS-1:0] hi_ff, hi_in;
   logic signed [COORD_BITS-1:0] mid_ff, mid_in;
   logic [NW-1:0]                node_ff, node_in;
   logic                         first_ff, first_in;
   logic [UW-1:0]                used_ff, used_in;
   logic                         empty_ff, empty_in;
   logic signed [LINE_BITS-1:0]  ps_ff, ps_in;
   logic signed [LINE_BITS-1:0]  pc_ff, pc_in;
   logic [NW-1:0]                left_ff, left_in;
   logic [NW-1:0]                right_ff, right_in;
   logic signed [DW-1:0]         ds_ff, ds_in;
   logic signed [DW-1:0]         dc_ff, dc_in;
   logic signed [PW-1:0]         prod_l_ff, prod_l_in;
   logic signed [PW-1:0]         prod_m_ff, prod_m_in;
   rsp_type                      res_ff, res_in;

   // memory ports
   logic          mem_we;
   logic [NW-1:0] mem_waddr;
   logic [NB-1:0] mem_wdata;
   logic [NB-1:0] rd_data;

   lcle_node_ram #(
      .DEPTH     (NODE_COUNT),
      .DATA_BITS (NB)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (state_ff == S_READ),
      .rd_addr (node_ff),
      .rd_data (rd_data)
   );

   // unpack the node read
   logic signed [LINE_BITS-1:0] rd_slope, rd_icpt;
   logic [NW-1:0]               rd_left, rd_right;
   assign rd_slope = rd_data[NB-1 -: LINE_BITS];
   assign rd_icpt  = rd_data[NB-LINE_BITS-1 -: LINE_BITS];
   assign rd_left  = rd_data[2*NW-1 -: NW];
   assign rd_right = rd_data[NW-1:0];

   // domain taken from the registers, inverted domain collapses to one point
   logic signed [COORD_BITS-1:0] dom_lo, dom_hi_raw, dom_hi, req_x;
   assign dom_lo     = cfg.domain_low[COORD_BITS-1:0];
   assign dom_hi_raw = cfg.domain_high[COORD_BITS-1:0];
   assign dom_hi     = (dom_hi_raw < dom_lo) ? dom_lo : dom_hi_raw;
   assign req_x      = req.query_x[COORD_BITS-1:0];

   // midpoint truncated toward zero
   logic signed [COORD_BITS:0] mid_sum, mid_adj;
   assign mid_sum = {lo_ff[COORD_BITS-1], lo_ff} + {hi_ff[COORD_BITS-1], hi_ff};
   assign mid_adj = mid_sum + {{COORD_BITS{1'b0}}, mid_sum[COORD_BITS]};

   // multiplier operand at the left end or at x
   logic signed [COORD_BITS-1:0] mul_x;
   assign mul_x = (op_ff == OP_QUERY) ? x_ff : lo_ff;

   // insert decisions: sign of (new - stored) at the left end and midpoint
   logic signed [EW-1:0] sum_l, sum_m;
   logic                 lef, mdec;
   assign sum_l = EW'(prod_l_ff) + EW'(dc_ff);
   assign sum_m = EW'(prod_m_ff) + EW'(dc_ff);
   assign lef  = cfg.keep_maximum ? (!sum_l[EW-1] && (|sum_l)) : sum_l[EW-1];
   assign mdec = cfg.keep_maximum ? (!sum_m[EW-1] && (|sum_m)) : sum_m[EW-1];

   // query value of the current node and its compare against the best
   logic signed [EW-1:0]         qsum;
   logic signed [VALUE_BITS-1:0] qv;
   logic                         qbetter;
   assign qsum    = EW'(prod_l_ff) + EW'(pc_ff);
   assign qv      = VALUE_BITS'(qsum);
   assign qbetter = cfg.keep_maximum ? (qv > res_ff.best_value) : (qv < res_ff.best_value);

   // line kept in the node and line carried down
   logic signed [LINE_BITS-1:0] keep_s, keep_c, carry_s, carry_c;
   logic                        go_left, pool_full;
   logic [NW-1:0]               link, new_idx;
   assign keep_s    = mdec ? slope_ff : ps_ff;
   assign keep_c    = mdec ? icpt_ff : pc_ff;
   assign carry_s   = mdec ? ps_ff : slope_ff;
   assign carry_c   = mdec ? pc_ff : icpt_ff;
   assign go_left   = (op_ff == OP_QUERY) ? (x_ff <= mid_ff) : (lef != mdec);
   assign link      = go_left ? left_ff : right_ff;
   assign pool_full = (used_ff == UW'(NODE_COUNT));
   assign new_idx   = used_ff[NW-1:0];

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      slope_in  = slope_ff;
      icpt_in   = icpt_ff;
      x_in      = x_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      node_in   = node_ff;
      first_in  = first_ff;
      used_in   = used_ff;
      empty_in  = empty_ff;
      ps_in     = ps_ff;
      pc_in     = pc_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      ds_in     = ds_ff;
      dc_in     = dc_ff;
      prod_l_in = prod_l_ff;
      prod_m_in = prod_m_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = node_ff;
      mem_wdata = {keep_s, keep_c, left_ff, right_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req.operation;
               slope_in = req.line_slope;
               icpt_in  = req.line_intercept;
               x_in     = req_x;
               lo_in    = dom_lo;
               hi_in    = dom_hi;
               node_in  = '0;
               first_in = 1'b1;
               res_in   = '0;
               if (req.operation == OP_INSERT) begin
                  if (empty_ff) begin
                     // first line goes straight into the root
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = {req.line_slope, req.line_intercept, {(2*NW){1'b0}}};
                     used_in   = UW'(1);
                     empty_in  = 1'b0;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end else if (empty_ff) begin
                  res_in.status = STATUS_EMPTY;
                  state_in      = S_DONE;
               end else if (req_x < dom_lo || req_x > dom_hi) begin
                  res_in.status = STATUS_OUTSIDE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            mid_in   = mid_adj[COORD_BITS:1];
            state_in = S_LOAD;
         end
         S_LOAD: begin
            ps_in    = rd_slope;
            pc_in    = rd_icpt;
            left_in  = rd_left;
            right_in = rd_right;
            if (op_ff == OP_QUERY) begin
               ds_in = DW'(rd_slope);
            end else begin
               ds_in = DW'(slope_ff) - DW'(rd_slope);
               dc_in = DW'(icpt_ff) - DW'(rd_icpt);
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_l_in = ds_ff * mul_x;
            prod_m_in = ds_ff * mid_ff;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (op_ff == OP_QUERY) begin
               // root always taken, deeper nodes only when strictly better
               if (first_ff || qbetter) begin
                  res_in.best_value     = qv;
                  res_in.best_slope     = ps_ff;
                  res_in.best_intercept = pc_ff;
               end
               first_in = 1'b0;
               if (lo_ff == hi_ff || link == '0) begin
                  state_in = S_DONE;
               end else begin
                  node_in  = link;
                  state_in = S_READ;
                  if (go_left) begin
                     hi_in = mid_ff;
                  end else begin
                     lo_in = mid_ff + COORD_BITS'(1);
                  end
               end
            end else begin
               // write back the node with the better line kept
               mem_we   = 1'b1;
               slope_in = carry_s;
               icpt_in  = carry_c;
               if (go_left) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + COORD_BITS'(1);
               end
               if (lo_ff == hi_ff) begin
                  state_in = S_DONE;
               end else if (link != '0) begin
                  node_in  = link;
                  state_in = S_READ;
               end else if (pool_full) begin
                  res_in.status = STATUS_FULL;
                  state_in      = S_DONE;
               end else begin
                  // hook the new child into this node
                  if (go_left) begin
                     mem_wdata = {keep_s, keep_c, new_idx, right_ff};
                  end else begin
                     mem_wdata = {keep_s, keep_c, left_ff, new_idx};
                  end
                  state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            mem_we    = 1'b1;
            mem_waddr = new_idx;
            mem_wdata = {slope_ff, icpt_ff, {(2*NW){1'b0}}};
            used_in   = used_ff + UW'(1);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         empty_ff <= empty_in;
      end
      op_ff     <= op_in;
      slope_ff  <= slope_in;
      icpt_ff   <= icpt_in;
      x_ff      <= x_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      node_ff   <= node_in;
      first_ff  <= first_in;
      ps_ff     <= ps_in;
      pc_ff     <= pc_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      ds_ff     <= ds_in;
      dc_ff     <= dc_in;
      prod_l_ff <= prod_l_in;
      prod_m_ff <= prod_m_in;
      res_ff    <= res_in;
   end

   assign busy   = (state_ff != S_IDLE);
   assign done   = (state_ff == S_DONE);
   assign result = res_ff;

endmodule

// ===== rtl/li_chao_line_envelope_core.sv =====
// top level of the line envelope core: config registers, result register
//
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_stall     operation, slope, intercept, x
//   rsp       out         rsp_valid / rsp_stall     best value, slope, intercept, status
//   csr       in          csr_write_enable          csr_index, csr_write_data
//
// one request at a time; each tree level steps through node read, load, the two
// multipliers, and compare with write-back, and an insert that allocates a new node
// adds an allocation step. requests on an empty tree or outside the domain skip the
// tree walk and go straight to the result.
// reset is synchronous; the node pool needs no clearing pass after reset.
// a held result stalls the walker only at its end; rsp_stall never blocks csr writes.
`include "assert_macros.svh"

module li_chao_line_envelope_core
   import lcle_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic signed [LINE_BITS-1:0]   req_line_slope,
   input  logic signed [LINE_BITS-1:0]   req_line_intercept,
   input  logic signed [LINE_BITS-1:0]   req_query_x,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_BITS-1:0]  rsp_best_value,
   output logic signed [LINE_BITS-1:0]   rsp_best_slope,
   output logic signed [LINE_BITS-1:0]   rsp_best_intercept,
   output logic [STATUS_BITS-1:0]        rsp_status,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data
);

   cfg_type cfg_ff;
   req_type req_bus;
   rsp_type walk_result, rsp_data_ff;
   logic    rsp_valid_ff;
   logic    walk_busy, walk_done, slot_free, start;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.domain_low   <= '0;
         cfg_ff.domain_high  <= CSR_DATA_BITS'(65535);
         cfg_ff.keep_maximum <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DOMAIN_LOW:   cfg_ff.domain_low   <= csr_write_data;
            CSR_DOMAIN_HIGH:  cfg_ff.domain_high  <= csr_write_data;
            CSR_KEEP_MAXIMUM: cfg_ff.keep_maximum <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // request bundle
   assign req_bus.operation      = req_operation;
   assign req_bus.line_slope     = req_line_slope;
   assign req_bus.line_intercept = req_line_intercept;
   assign req_bus.query_x        = req_query_x;

   assign start     = req_valid && !walk_busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   lcle_walker #(
      .NODE_COUNT (NODE_COUNT),
      .COORD_BITS (COORD_BITS)
   ) u_walker (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_bus),
      .cfg    (cfg_ff),
      .take   (slot_free),
      .busy   (walk_busy),
      .done   (walk_done),
      .result (walk_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (walk_done && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (walk_done && slot_free) begin
         rsp_data_ff <= walk_result;
      end
   end

   assign req_stall          = walk_busy;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_best_value     = rsp_data_ff.best_value;
   assign rsp_best_slope     = rsp_data_ff.best_slope;
   assign rsp_best_intercept = rsp_data_ff.best_intercept;
   assign rsp_status         = rsp_data_ff.status;

   // checks
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_NEXT(a_done_waits_for_slot, clock, reset, walk_done && !slot_free, walk_done)
   `ASSERT_IMPLY(a_done_means_busy, clock, reset, walk_done, req_stall)
   `ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY, rsp_best_value == '0 && rsp_best_slope == '0)

endmodule
